// ===== rtl/h264fu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package h264fu_pkg;

  localparam int PAYLOAD_LIMIT_DEF = 8192;

  localparam logic [13:0] MAX_PAYLOAD_RST = 14'd1400;
  localparam logic [31:0] TS_STEP_RST     = 32'(90000 / 25);

  // NAL header fields
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] TYPE_FU_A = 8'd28;
  localparam logic [7:0] TYPE_SPS  = 8'd7;
  localparam logic [7:0] TYPE_PPS  = 8'd8;
  localparam logic [7:0] FU_S_BIT  = 8'h80;
  localparam logic [7:0] FU_E_BIT  = 8'h40;

  // register map, word index
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic REG_TS_STEP     = 1'b1;

  typedef struct packed {
    logic [13:0] max_payload;
    logic [31:0] timestamp_step;
  } cfg_t;

  // results caused by one input byte
  typedef struct packed {
    logic        fu;      // FU indicator and FU header precede the data byte
    logic [7:0]  ind;
    logic [7:0]  hdr;
    logic [7:0]  data;
    logic        pf;
    logic        pl;
    logic [15:0] seq;
    logic [31:0] ts;
  } bundle_t;

  typedef enum logic [1:0] {
    SLOT_IND,
    SLOT_HDR,
    SLOT_DATA
  } slot_t;

endpackage

`default_nettype wire

// ===== rtl/h264fu_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h264fu_cfg
  import h264fu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  logic wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload    <= MAX_PAYLOAD_RST;
      cfg.timestamp_step <= TS_STEP_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_PAYLOAD: cfg.max_payload    <= pwdata[13:0];
        REG_TS_STEP:     cfg.timestamp_step <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_PAYLOAD: prdata = {18'd0, cfg.max_payload};
      REG_TS_STEP:     prdata = cfg.timestamp_step;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/h264fu_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h264fu_core
  import h264fu_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        nal_first,
  input  wire logic [23:0] nal_length,
  output logic             emit,
  output bundle_t          bundle
);

  localparam int LW = $clog2(PAYLOAD_LIMIT + 1);

  logic [7:0]    nal_header, nal_header_next;
  logic          fragment_mode, fragment_mode_next;
  logic [23:0]   bytes_remaining, bytes_remaining_next;
  logic [LW-1:0] fragment_fill, fragment_fill_next;
  logic          first_fragment, first_fragment_next;
  logic [15:0]   seq_counter, seq_counter_next;
  logic [31:0]   time_counter, time_counter_next;

  logic [LW-1:0] limit;
  logic [23:0]   len;
  logic          abandon;
  logic [15:0]   seq_put;
  logic          unit_end;
  logic          pkt_end;
  logic [7:0]    cur_type;
  logic [7:0]    new_type;
  logic          cur_timed;
  logic          new_timed;

  // effective payload limit, clamped to 1..PAYLOAD_LIMIT
  always_comb begin
    if (cfg.max_payload == '0) begin
      limit = LW'(1);
    end else if (32'(cfg.max_payload) > 32'(PAYLOAD_LIMIT)) begin
      limit = LW'(PAYLOAD_LIMIT);
    end else begin
      limit = LW'(cfg.max_payload);
    end
  end

  assign len       = (nal_length == '0) ? 24'd1 : nal_length;
  assign abandon   = (bytes_remaining != '0) && (!fragment_mode || (fragment_fill != '0));
  assign seq_put   = seq_counter + 16'(abandon);
  assign unit_end  = (bytes_remaining == 24'd1);
  assign pkt_end   = unit_end || ((LW + 1)'(fragment_fill) + (LW + 1)'(1) >= (LW + 1)'(limit));
  assign cur_type  = nal_header & TYPE_MASK;
  assign new_type  = data_byte & TYPE_MASK;
  assign cur_timed = (cur_type != TYPE_SPS) && (cur_type != TYPE_PPS);
  assign new_timed = (new_type != TYPE_SPS) && (new_type != TYPE_PPS);

  always_comb begin
    nal_header_next      = nal_header;
    fragment_mode_next   = fragment_mode;
    bytes_remaining_next = bytes_remaining;
    fragment_fill_next   = fragment_fill;
    first_fragment_next  = first_fragment;
    seq_counter_next     = seq_counter;
    time_counter_next    = time_counter;

    emit        = 1'b0;
    bundle.fu   = 1'b0;
    bundle.ind  = (nal_header & NRI_MASK) | TYPE_FU_A;
    bundle.hdr  = (nal_header & TYPE_MASK)
                | (first_fragment ? FU_S_BIT : 8'h00)
                | ((bytes_remaining <= 24'(limit)) ? FU_E_BIT : 8'h00);
    bundle.data = data_byte;
    bundle.pf   = 1'b0;
    bundle.pl   = 1'b0;
    bundle.seq  = seq_counter;
    bundle.ts   = time_counter;

    if (nal_first) begin
      bundle.seq           = seq_put;
      seq_counter_next     = seq_put;
      nal_header_next      = data_byte;
      fragment_fill_next   = '0;
      bytes_remaining_next = len - 24'd1;
      if (len <= 24'(limit)) begin
        fragment_mode_next  = 1'b0;
        first_fragment_next = 1'b0;
        emit                = 1'b1;
        bundle.pf           = 1'b1;
        bundle.pl           = (len == 24'd1);
        if (len == 24'd1) begin
          seq_counter_next = seq_put + 16'd1;
          if (new_timed) time_counter_next = time_counter + cfg.timestamp_step;
        end
      end else begin
        fragment_mode_next  = 1'b1;
        first_fragment_next = 1'b1;
      end
    end else if (bytes_remaining != '0) begin
      emit                 = 1'b1;
      bytes_remaining_next = bytes_remaining - 24'd1;
      if (unit_end && cur_timed) time_counter_next = time_counter + cfg.timestamp_step;
      if (!fragment_mode) begin
        bundle.pl = unit_end;
        if (unit_end) seq_counter_next = seq_counter + 16'd1;
      end else begin
        bundle.fu = (fragment_fill == '0);
        if (fragment_fill == '0) first_fragment_next = 1'b0;
        bundle.pl          = pkt_end;
        fragment_fill_next = pkt_end ? '0 : fragment_fill + LW'(1);
        if (pkt_end) seq_counter_next = seq_counter + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_header      <= '0;
      fragment_mode   <= 1'b0;
      bytes_remaining <= '0;
      fragment_fill   <= '0;
      first_fragment  <= 1'b0;
      seq_counter     <= '0;
      time_counter    <= '0;
    end else if (accept) begin
      nal_header      <= nal_header_next;
      fragment_mode   <= fragment_mode_next;
      bytes_remaining <= bytes_remaining_next;
      fragment_fill   <= fragment_fill_next;
      first_fragment  <= first_fragment_next;
      seq_counter     <= seq_counter_next;
      time_counter    <= time_counter_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/h264fu_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h264fu_out
  import h264fu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    accept,
  input  wire logic    emit,
  input  wire bundle_t bundle_in,
  output logic         in_ready,
  output logic         m_tvalid,
  input  wire logic    m_tready,
  output logic [55:0]  m_tdata,
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  bundle_t bundle;
  logic    valid;
  slot_t   slot, slot_next;
  logic    load;
  logic    take;
  logic    done;
  logic [7:0] byte_sel;
  logic       pf_sel;
  logic       pl_sel;

  assign load     = accept && emit;
  assign take     = valid && m_tready;
  assign done     = (slot == SLOT_DATA);
  assign in_ready = !valid || (m_tready && done);

  always_comb begin
    slot_next = slot;
    if (load) begin
      slot_next = bundle_in.fu ? SLOT_IND : SLOT_DATA;
    end else if (take) begin
      unique case (slot)
        SLOT_IND:  slot_next = SLOT_HDR;
        SLOT_HDR:  slot_next = SLOT_DATA;
        SLOT_DATA: slot_next = SLOT_DATA;
        default:   slot_next = SLOT_DATA;
      endcase
    end
  end

  always_comb begin
    unique case (slot)
      SLOT_IND: begin
        byte_sel = bundle.ind;
        pf_sel   = 1'b1;
        pl_sel   = 1'b0;
      end
      SLOT_HDR: begin
        byte_sel = bundle.hdr;
        pf_sel   = 1'b0;
        pl_sel   = 1'b0;
      end
      default: begin
        byte_sel = bundle.data;
        pf_sel   = bundle.pf;
        pl_sel   = bundle.pl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      slot  <= SLOT_DATA;
    end else begin
      slot <= slot_next;
      if (load) begin
        valid <= 1'b1;
      end else if (take && done) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) bundle <= bundle_in;
  end

  assign m_tvalid = valid;
  assign m_tdata  = {bundle.ts, bundle.seq, byte_sel};
  assign m_tuser  = {pl_sel, pf_sel};
  assign m_tlast  = done;

endmodule

`default_nettype wire

// ===== rtl/h264_nal_rtp_fua_packetizer_top.sv =====
// H.264 NAL unit to RTP payload packetizer (single NAL unit and FU-A modes).
// Feed one NAL byte per request, header byte first with s_tuser high and the
// unit length in s_tdata[31:8]. Units up to max_payload bytes leave as one
// packet; longer ones are cut into FU-A fragments with FU indicator and FU
// header bytes inserted. A byte that opens a fragment yields three output
// bytes, so the output register holds it until all three have left and the
// input waits meanwhile. Output is taken from a single result register with
// a slot counter, so a new byte is accepted in the same cycle the last result
// of the previous one leaves. Configuration writes go in only while the
// stream is idle; the user must keep to this, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module h264_nal_rtp_fua_packetizer_top
  import h264fu_pkg::*;
#(
  parameter int PAYLOAD_LIMIT = PAYLOAD_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [7:0] data_byte, [31:8] nal_length
  input  wire logic        s_tuser,   // [0] nal_first
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] out_byte, [23:8] sequence_number,
                                      // [55:24] rtp_timestamp
  output logic [1:0]       m_tuser,   // [0] packet_first, [1] packet_last
  output logic             m_tlast,   // run_last
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t    cfg;
  bundle_t bundle;
  logic    emit;
  logic    accept;

  assign pready = 1'b1;
  assign accept = s_tvalid && s_tready;

  h264fu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  h264fu_core #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .data_byte  (s_tdata[7:0]),
    .nal_first  (s_tuser),
    .nal_length (s_tdata[31:8]),
    .emit       (emit),
    .bundle     (bundle)
  );

  h264fu_out u_out (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .emit      (emit),
    .bundle_in (bundle),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/h264fu_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module h264fu_chk
  import h264fu_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [55:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // an empty output stage never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // a payload start that is not the data byte is an FU indicator
  a_ind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && !m_tlast |-> m_tdata[4:0] == TYPE_FU_A[4:0] && !m_tuser[1])
    else $error("bad FU indicator");

  // FU header follows the indicator at once
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser[0] && !m_tlast
      |=> m_tvalid && !m_tuser[0] && !m_tuser[1] && !m_tlast)
    else $error("FU header missing");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind h264_nal_rtp_fua_packetizer_top h264fu_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
